### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL that checks its own behavior.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/core/tksel_pkg.sv
// ---------------------------------------------------------------------------
// tksel_pkg
// Types, codes and the ranking function shared by the top-k selector.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tksel_pkg;

    // Input command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DRAIN  = 1'b1;

    // Result kind codes
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DRAIN  = 1'b1;

    // Insert status codes
    localparam logic [1:0] ST_DROPPED  = 2'd0;
    localparam logic [1:0] ST_ADDED    = 2'd1;
    localparam logic [1:0] ST_REPLACED = 2'd2;
    localparam logic [1:0] ST_REJECTED = 2'd3;

    // One kept entry
    typedef struct packed {
        logic signed [31:0] score;
        logic [31:0]        doc;
    } entry_t;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic insert;
        logic shift_up;
    } cell_ctrl_t;

    // True when a ranks strictly above b: higher score, then smaller id
    function automatic logic ranks_above(entry_t a, entry_t b);
        logic result;
        if (a.score != b.score)
            result = (a.score > b.score);
        else
            result = (a.doc < b.doc);
        return result;
    endfunction

endpackage

### rtl/core/tksel_cell.sv
// ---------------------------------------------------------------------------
// tksel_cell
// One slot of the sorted chain: compares the candidate with its entry and
// takes the candidate, its upper neighbor's entry, or its lower neighbor's.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tksel_cell
(
    input  logic                clk,
    input  tksel_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  tksel_pkg::entry_t   cand,
    input  tksel_pkg::entry_t   prev_entry,
    input  logic                prev_beats,
    input  tksel_pkg::entry_t   next_entry,
    output tksel_pkg::entry_t   entry,
    output logic                beats
);

    tksel_pkg::entry_t entry_reg;
    tksel_pkg::entry_t entry_next;

    // Candidate belongs at or above this slot when the slot is empty or outranked
    assign beats = !occupied || tksel_pkg::ranks_above(cand, entry_reg);
    assign entry = entry_reg;

    // Insert: take the neighbor's entry if the candidate lands higher, else the candidate
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert && beats)
        begin
            entry_next = prev_beats ? prev_entry : cand;
        end
        else if (ctrl.shift_up)
        begin
            entry_next = next_entry;
        end
    end

    // Hold the entry
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

### rtl/core/tksel_chain.sv
// ---------------------------------------------------------------------------
// tksel_chain
// Row of cells holding the kept entries in rank order, best at cell zero,
// with the worst-entry compare and the tail score select.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tksel_chain
#(
    parameter int DEPTH = 16,
    parameter int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic                  clk,
    input  tksel_pkg::cell_ctrl_t ctrl,
    input  tksel_pkg::entry_t     cand,
    input  logic [CNT_W-1:0]      count,
    output logic                  beat_held,
    output tksel_pkg::entry_t     head,
    output logic signed [31:0]    tail_score
);

    tksel_pkg::entry_t entries [DEPTH];
    logic [DEPTH-1:0]  beats;
    logic [DEPTH-1:0]  occ;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            tksel_pkg::entry_t prev_e;
            tksel_pkg::entry_t next_e;
            logic              prev_b;

            assign occ[gi] = (32'(count) > 32'(gi));

            if (gi == 0)
            begin : g_first
                assign prev_e = cand;
                assign prev_b = 1'b0;
            end
            else
            begin : g_mid
                assign prev_e = entries[gi-1];
                assign prev_b = beats[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign next_e = entries[gi];
            end
            else
            begin : g_inner
                assign next_e = entries[gi+1];
            end

            tksel_cell u_cell
            (
                .clk        (clk),
                .ctrl       (ctrl),
                .occupied   (occ[gi]),
                .cand       (cand),
                .prev_entry (prev_e),
                .prev_beats (prev_b),
                .next_entry (next_e),
                .entry      (entries[gi]),
                .beats      (beats[gi])
            );
        end
    endgenerate

    // Candidate outranks the worst held entry when it outranks any held entry
    assign beat_held = |(beats & occ);
    assign head      = entries[0];

    // Select the score of the last held entry
    always_comb
    begin
        tail_score = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (32'(count) == 32'(i + 1))
                tail_score = tail_score | entries[i].score;
        end
    end

endmodule

### rtl/core/top_k_score_selector.sv
// ---------------------------------------------------------------------------
// top_k_score_selector
// Keeps the best k scored documents in a sorted chain of cells and drains
// them best first on request.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries command, doc_id and
//   score; a transaction is taken when in_valid is high and in_stall low.
//   Output channel (out_valid / out_stall) carries an insert's result or
//   a drain's results; the receiver holds out_stall high to pause it.
//   keep_count is to be written through cfg_valid / cfg_ready only while
//   the block is idle, which it does not enforce; cfg_ready is always high.
//   Insert: the chain compares and shifts in the accept cycle, the status
//   result is registered and then loaded into the output register after
//   the tail score select; the next insert waits until it is loaded.
//   Drain of n entries: n results (one if empty), one per cycle while the
//   output is not stalled, each shifting the chain toward cell zero.
//   in_stall is high whenever a transaction is still in progress; a
//   stalled output register holds its result and the block waits.
//   Reset clears the held count, threshold, keep_count (to 16) and the
//   control state; the stored entries need no clearing.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module top_k_score_selector
#(
    parameter int  MAX_KEEP = 16,
    localparam int CNT_W    = $clog2(MAX_KEEP + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [4:0]               keep_count,
    // input channel
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     command,
    input  logic [31:0]              doc_id,
    input  logic signed [31:0]       score,
    // output channel
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     kind,
    output logic [1:0]               status,
    output logic                     entry_valid,
    output logic [31:0]              result_document,
    output logic signed [31:0]       result_score,
    output logic signed [31:0]       threshold,
    output logic [CNT_W-1:0]         held_count,
    output logic                     last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_DRAIN
    } state_t;

    state_t                 state_reg, state_next;
    logic [4:0]             keep_reg, keep_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic signed [31:0]     thr_reg, thr_next;
    logic [1:0]             ins_status_reg, ins_status_next;
    logic                   thr_upd_reg, thr_upd_next;
    logic [CNT_W-1:0]       drain_left_reg, drain_left_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   kind_reg, kind_next;
    logic [1:0]             status_reg, status_next;
    logic                   entry_valid_reg, entry_valid_next;
    logic [31:0]            doc_reg, doc_next;
    logic signed [31:0]     score_reg, score_next;
    logic signed [31:0]     threshold_reg, threshold_next;
    logic [CNT_W-1:0]       held_reg, held_next;
    logic                   last_reg, last_next;

    tksel_pkg::cell_ctrl_t  ctrl;
    tksel_pkg::entry_t      cand;
    tksel_pkg::entry_t      head;
    logic                   beat_held;
    logic signed [31:0]     tail_score;
    logic [CNT_W-1:0]       k_eff;
    logic                   out_free;
    logic signed [31:0]     thr_new;

    // Saturate k at the chain depth
    assign k_eff = (32'(keep_reg) > MAX_KEEP) ? CNT_W'(MAX_KEEP) : CNT_W'(keep_reg);

    assign cand.score = score;
    assign cand.doc   = doc_id;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    tksel_chain #(
        .DEPTH (MAX_KEEP),
        .CNT_W (CNT_W)
    ) u_chain (
        .clk        (clk),
        .ctrl       (ctrl),
        .cand       (cand),
        .count      (count_reg),
        .beat_held  (beat_held),
        .head       (head),
        .tail_score (tail_score)
    );

    // Sequence inserts and drains, load the output register
    always_comb
    begin
        state_next       = state_reg;
        keep_next        = keep_reg;
        count_next       = count_reg;
        thr_next         = thr_reg;
        ins_status_next  = ins_status_reg;
        thr_upd_next     = thr_upd_reg;
        drain_left_next  = drain_left_reg;
        out_valid_next   = out_valid_reg;
        kind_next        = kind_reg;
        status_next      = status_reg;
        entry_valid_next = entry_valid_reg;
        doc_next         = doc_reg;
        score_next       = score_reg;
        threshold_next   = threshold_reg;
        held_next        = held_reg;
        last_next        = last_reg;
        ctrl             = '0;
        thr_new          = thr_reg;

        if (cfg_valid)
            keep_next = keep_count;

        // Drop the result once taken
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (command == tksel_pkg::CMD_DRAIN)
                    begin
                        drain_left_next = count_reg;
                        count_next      = '0;
                        thr_next        = '0;
                        state_next      = S_DRAIN;
                    end
                    else
                    begin
                        thr_upd_next = (score > 0) && (k_eff != '0);
                        if (score <= 0)
                            ins_status_next = tksel_pkg::ST_DROPPED;
                        else if (k_eff == '0)
                            ins_status_next = tksel_pkg::ST_REJECTED;
                        else if (count_reg < k_eff)
                        begin
                            ins_status_next = tksel_pkg::ST_ADDED;
                            ctrl.insert     = 1'b1;
                            count_next      = count_reg + 1'b1;
                        end
                        else if (beat_held)
                        begin
                            ins_status_next = tksel_pkg::ST_REPLACED;
                            ctrl.insert     = 1'b1;
                        end
                        else
                            ins_status_next = tksel_pkg::ST_REJECTED;
                        state_next = S_INS;
                    end
                end
            end

            S_INS:
            begin
                if (thr_upd_reg && (count_reg >= k_eff))
                    thr_new = tail_score;
                if (out_free)
                begin
                    thr_next         = thr_new;
                    out_valid_next   = 1'b1;
                    kind_next        = tksel_pkg::KIND_INSERT;
                    status_next      = ins_status_reg;
                    entry_valid_next = 1'b0;
                    doc_next         = '0;
                    score_next       = '0;
                    threshold_next   = thr_new;
                    held_next        = count_reg;
                    last_next        = 1'b1;
                    state_next       = S_IDLE;
                end
            end

            S_DRAIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = tksel_pkg::KIND_DRAIN;
                    status_next    = tksel_pkg::ST_DROPPED;
                    threshold_next = '0;
                    held_next      = '0;
                    if (drain_left_reg == '0)
                    begin
                        entry_valid_next = 1'b0;
                        doc_next         = '0;
                        score_next       = '0;
                        last_next        = 1'b1;
                        state_next       = S_IDLE;
                    end
                    else
                    begin
                        entry_valid_next = 1'b1;
                        doc_next         = head.doc;
                        score_next       = head.score;
                        last_next        = (drain_left_reg == CNT_W'(1));
                        ctrl.shift_up    = 1'b1;
                        drain_left_next  = drain_left_reg - 1'b1;
                        if (drain_left_reg == CNT_W'(1))
                            state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            keep_reg        <= 5'd16;
            count_reg       <= '0;
            thr_reg         <= '0;
            ins_status_reg  <= tksel_pkg::ST_DROPPED;
            thr_upd_reg     <= 1'b0;
            drain_left_reg  <= '0;
            out_valid_reg   <= 1'b0;
            kind_reg        <= tksel_pkg::KIND_INSERT;
            status_reg      <= tksel_pkg::ST_DROPPED;
            entry_valid_reg <= 1'b0;
            doc_reg         <= '0;
            score_reg       <= '0;
            threshold_reg   <= '0;
            held_reg        <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            keep_reg        <= keep_next;
            count_reg       <= count_next;
            thr_reg         <= thr_next;
            ins_status_reg  <= ins_status_next;
            thr_upd_reg     <= thr_upd_next;
            drain_left_reg  <= drain_left_next;
            out_valid_reg   <= out_valid_next;
            kind_reg        <= kind_next;
            status_reg      <= status_next;
            entry_valid_reg <= entry_valid_next;
            doc_reg         <= doc_next;
            score_reg       <= score_next;
            threshold_reg   <= threshold_next;
            held_reg        <= held_next;
            last_reg        <= last_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign kind            = kind_reg;
    assign status          = status_reg;
    assign entry_valid     = entry_valid_reg;
    assign result_document = doc_reg;
    assign result_score    = score_reg;
    assign threshold       = threshold_reg;
    assign held_count      = held_reg;
    assign last            = last_reg;

    // Held count never exceeds the chain depth
    `ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, 32'(count_reg) <= MAX_KEEP)
    // An accepted transaction keeps the input stalled in the next cycle
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    // A drain empties the store and clears the threshold
    `ASSERT_NEXT(a_drain_clears, clk, rst_n,
        in_valid && !in_stall && (command == tksel_pkg::CMD_DRAIN),
        (count_reg == '0) && (thr_reg == '0))
    // Insert results carry no entry and are marked last
    `ASSERT_IMPLY(a_insert_no_entry, clk, rst_n,
        out_valid && (kind == tksel_pkg::KIND_INSERT), !entry_valid && last)

endmodule
